// ----- design/gmabr_pkg.sv -----
// ----------------------------------------------------------------------------
// gmabr_pkg
// Shared types and constants for the gyro moving average bias removal core.
// ----------------------------------------------------------------------------
package gmabr_pkg;

   localparam int SAMPLE_W = 16;                      // input sample width
   localparam int OUT_W    = 32;                      // result width
   localparam int CNT_W    = 16;                      // calibration counter width
   localparam int SCALE_W  = 12;                      // signed width of the scale
   localparam logic signed [SCALE_W-1:0] RAD_SCALE = 12'sd1144;
   localparam logic [CNT_W-1:0] CALIB_RESET = 16'd3500;

   // one history entry: angle and rate sample of one word
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] vel;
      logic signed [SAMPLE_W-1:0] pos;
   } sample_pair_type;

endpackage

// ----- design/gyro_moving_average_bias_removal_core.sv -----
// ----------------------------------------------------------------------------
// gyro_moving_average_bias_removal_core
// Moving average over DEPTH gyro samples per channel, constant bias removal
// and scaling to radians in signed Q4.27.
// ----------------------------------------------------------------------------
// Use:
//   req_* takes one word per sample pair (angle and rate, 1/128 degree).
//   rsp_* returns one word per accepted request: both filtered channels and
//   a calibrating flag in rsp_tuser. csr_* writes the calibration count; the
//   user must write it with no word in flight; the block does not enforce it.
// Pipeline: a word accepted on req_* passes the history read, window sum,
//   scale multiply and saturation registers in order before it reaches rsp_*.
// Throughput: one word per cycle when not stalled. The history memory is read
//   and written at the same slot in the accept cycle (read-first), and the
//   window sums are updated once per word in a single add/subtract stage.
// Reset: clears the window sums, bias, counters and the per-slot valid
//   bits, so never-written history slots read as zero; no clearing pass.
//   The calibration count returns to 3500.
// Stall: when rsp_tready is low the result holds; the three stages before
//   it keep filling, and req_tready falls only once all of them are full.
// ----------------------------------------------------------------------------
module gyro_moving_average_bias_removal_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request: [15:0] pos_sample, [31:16] vel_sample
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: [31:0] pos_rad, [63:32] vel_rad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // response: [0] calibrating
   output logic        rsp_tuser,
   // calibration count write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W  = gmabr_pkg::SAMPLE_W + IDX_W;
   localparam int DIFF_W = SUM_W + 1;
   localparam int PROD_W = DIFF_W + gmabr_pkg::SCALE_W;
   localparam int EXT_W  = (PROD_W > gmabr_pkg::OUT_W) ? PROD_W : gmabr_pkg::OUT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   localparam logic signed [gmabr_pkg::OUT_W-1:0] SAT_MAX = {1'b0, {(gmabr_pkg::OUT_W-1){1'b1}}};
   localparam logic signed [gmabr_pkg::OUT_W-1:0] SAT_MIN = {1'b1, {(gmabr_pkg::OUT_W-1){1'b0}}};

   // ---------------- configuration ----------------
   logic [gmabr_pkg::CNT_W-1:0] calib_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_count_ff <= gmabr_pkg::CALIB_RESET;
      end else if (csr_valid) begin
         calib_count_ff <= csr_data;
      end
   end

   // ---------------- pipeline control ----------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, out_vld_ff;
   logic out_free, s3_free, s2_free, s1_free;
   logic req_fire, s1_fire, s2_fire, s3_fire;

   assign out_free = !out_vld_ff || rsp_tready;
   assign s3_free  = !s3_vld_ff || out_free;
   assign s2_free  = !s2_vld_ff || s3_free;
   assign s1_free  = !s1_vld_ff || s2_free;

   assign req_tready = s1_free;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_fire    = s1_vld_ff && s2_free;
   assign s2_fire    = s2_vld_ff && s3_free;
   assign s3_fire    = s3_vld_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= req_fire || (s1_vld_ff && !s2_free);
         s2_vld_ff  <= s1_fire  || (s2_vld_ff && !s3_free);
         s3_vld_ff  <= s2_fire  || (s3_vld_ff && !out_free);
         out_vld_ff <= s3_fire  || (out_vld_ff && !rsp_tready);
      end
   end

   // ---------------- history memory, read-first ----------------
   gmabr_pkg::sample_pair_type hist_mem [DEPTH];
   logic [DEPTH-1:0]           hist_vld_ff;
   logic [IDX_W-1:0]           ring_idx_ff;
   gmabr_pkg::sample_pair_type rd_data_ff;
   logic                       rd_vld_ff;
   gmabr_pkg::sample_pair_type new_ff;
   gmabr_pkg::sample_pair_type req_word;

   assign req_word = gmabr_pkg::sample_pair_type'(req_tdata);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff            <= hist_mem[ring_idx_ff];
         hist_mem[ring_idx_ff] <= req_word;
         new_ff                <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         ring_idx_ff <= '0;
      end else if (req_fire) begin
         rd_vld_ff                <= hist_vld_ff[ring_idx_ff];
         hist_vld_ff[ring_idx_ff] <= 1'b1;
         ring_idx_ff              <= (ring_idx_ff == LAST_IDX) ? '0 : ring_idx_ff + 1'b1;
      end
   end

   // ---------------- window sums and bias ----------------
   logic signed [SUM_W-1:0]  pos_sum_ff, vel_sum_ff, pos_sum_in, vel_sum_in;
   logic signed [SUM_W-1:0]  pos_bias_ff, vel_bias_ff;
   logic [gmabr_pkg::CNT_W-1:0] sample_cnt_ff, sample_cnt_in;
   logic signed [gmabr_pkg::SAMPLE_W-1:0] pos_old, vel_old;
   logic                     s1_calib;
   logic signed [DIFF_W-1:0] pos_diff_in, vel_diff_in;
   logic signed [DIFF_W-1:0] pos_diff_ff, vel_diff_ff;
   logic                     s2_calib_ff;

   always_comb begin
      // never-written slots read as zero
      pos_old       = rd_vld_ff ? rd_data_ff.pos : '0;
      vel_old       = rd_vld_ff ? rd_data_ff.vel : '0;
      pos_sum_in    = pos_sum_ff + SUM_W'(new_ff.pos) - SUM_W'(pos_old);
      vel_sum_in    = vel_sum_ff + SUM_W'(new_ff.vel) - SUM_W'(vel_old);
      s1_calib      = sample_cnt_ff < calib_count_ff;
      sample_cnt_in = sample_cnt_ff + 1'b1;
      if (s1_calib) begin
         pos_diff_in = DIFF_W'(pos_sum_in);
         vel_diff_in = DIFF_W'(vel_sum_in);
      end else begin
         pos_diff_in = DIFF_W'(pos_sum_in) - DIFF_W'(pos_bias_ff);
         vel_diff_in = DIFF_W'(vel_sum_in) - DIFF_W'(vel_bias_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_sum_ff    <= '0;
         vel_sum_ff    <= '0;
         pos_bias_ff   <= '0;
         vel_bias_ff   <= '0;
         sample_cnt_ff <= '0;
      end else if (s1_fire) begin
         pos_sum_ff <= pos_sum_in;
         vel_sum_ff <= vel_sum_in;
         if (s1_calib) begin
            sample_cnt_ff <= sample_cnt_in;
            // capture bias on the word that completes calibration
            if (sample_cnt_in == calib_count_ff) begin
               pos_bias_ff <= pos_sum_in;
               vel_bias_ff <= vel_sum_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         pos_diff_ff <= pos_diff_in;
         vel_diff_ff <= vel_diff_in;
         s2_calib_ff <= s1_calib;
      end
   end

   // ---------------- scale ----------------
   logic signed [PROD_W-1:0] pos_prod_ff, vel_prod_ff;
   logic                     s3_calib_ff;

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         pos_prod_ff <= PROD_W'(pos_diff_ff) * PROD_W'(gmabr_pkg::RAD_SCALE);
         vel_prod_ff <= PROD_W'(vel_diff_ff) * PROD_W'(gmabr_pkg::RAD_SCALE);
         s3_calib_ff <= s2_calib_ff;
      end
   end

   // ---------------- saturate ----------------
   function automatic logic signed [gmabr_pkg::OUT_W-1:0] sat32(
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [EXT_W-1:0] ext;
      logic [EXT_W-gmabr_pkg::OUT_W:0] hi;
      ext = EXT_W'(prod);
      hi  = ext[EXT_W-1:gmabr_pkg::OUT_W-1];
      if (&hi || ~|hi) begin
         return ext[gmabr_pkg::OUT_W-1:0];
      end else if (ext[EXT_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   logic signed [gmabr_pkg::OUT_W-1:0] pos_rad_ff, vel_rad_ff;
   logic                               calib_out_ff;

   always_ff @(posedge clock) begin
      if (s3_fire) begin
         pos_rad_ff   <= sat32(pos_prod_ff);
         vel_rad_ff   <= sat32(vel_prod_ff);
         calib_out_ff <= s3_calib_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {vel_rad_ff, pos_rad_ff};
   assign rsp_tuser  = calib_out_ff;

   // ---------------- assertions ----------------
   a_fire_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_vld_ff)
      else $error("accepted word did not reach the sum stage");

   a_ring_steps : assert property (@(posedge clock) disable iff (reset)
      req_fire && (ring_idx_ff != LAST_IDX) |=> ring_idx_ff == $past(ring_idx_ff) + 1'b1)
      else $error("ring index did not step by one");

   a_bias_frozen : assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_calib |=> $stable(pos_bias_ff) && $stable(vel_bias_ff))
      else $error("bias changed outside calibration");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready && s1_vld_ff && s2_vld_ff && s3_vld_ff |-> !req_tready)
      else $error("request taken while the pipeline is full and stalled");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gyro moving average bias removal core. A burst
// driver feeds angle/rate sample pairs, a monitor with a changing stall
// pattern checks each result word against an in-bench window/bias predictor,
// and the calibration count is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     SAMPLE_W   = gmabr_pkg::SAMPLE_W;
   localparam int     OUT_W      = gmabr_pkg::OUT_W;
   localparam int     CNT_W      = gmabr_pkg::CNT_W;
   localparam int     IDLE_LIMIT = 3000;
   localparam int     SETTLE     = 8;
   localparam longint RAD_MAX    = 64'sd2147483647;
   localparam longint RAD_MIN    = -64'sd2147483648;

   typedef struct packed {
      logic signed [OUT_W-1:0] pos;
      logic signed [OUT_W-1:0] vel;
      logic                    calib;
   } rad_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   gyro_moving_average_bias_removal_core #(
      .DEPTH(16)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // filter state mirrored in the bench
   logic signed [SAMPLE_W-1:0] pos_ring [16];
   logic signed [SAMPLE_W-1:0] vel_ring [16];
   logic [3:0]                 ring_slot;
   longint                     pos_sum, vel_sum, pos_bias, vel_bias;
   int unsigned                calib_seen;
   logic [CNT_W-1:0]           calib_limit;

   gmabr_pkg::sample_pair_type sample_queue [$];
   rad_word_type               expected_rad [$];

   int mismatches  = 0;
   int words_sent  = 0;
   int flagged     = 0;
   int csr_writes  = 0;
   int idle_cycles = 0;

   function automatic logic signed [OUT_W-1:0] to_rad(input longint diff);
      longint prod;
      prod = diff * longint'(gmabr_pkg::RAD_SCALE);
      if (prod > RAD_MAX) prod = RAD_MAX;
      if (prod < RAD_MIN) prod = RAD_MIN;
      return prod[OUT_W-1:0];
   endfunction

   task automatic filter_pair(input gmabr_pkg::sample_pair_type s);
      rad_word_type r;
      logic         in_calib;
      in_calib = calib_seen < calib_limit;
      pos_sum = pos_sum + s.pos - pos_ring[ring_slot];
      vel_sum = vel_sum + s.vel - vel_ring[ring_slot];
      pos_ring[ring_slot] = s.pos;
      vel_ring[ring_slot] = s.vel;
      ring_slot = ring_slot + 4'd1;
      r.calib = in_calib;
      if (in_calib) begin
         r.pos = to_rad(pos_sum);
         r.vel = to_rad(vel_sum);
         calib_seen++;
         flagged++;
         // bias latched by the word that completes the count
         if (calib_seen == calib_limit) begin
            pos_bias = pos_sum;
            vel_bias = vel_sum;
         end
      end else begin
         r.pos = to_rad(pos_sum - pos_bias);
         r.vel = to_rad(vel_sum - vel_bias);
      end
      expected_rad = {expected_rad, r};
   endtask

   // request driver: bursts of random length separated by random gaps
   logic                       req_fired;
   int                         burst_left = 1;
   int                         gap_left   = 0;
   gmabr_pkg::sample_pair_type next_pair;

   always begin
      @(posedge clock);
      req_fired = req_tvalid && req_tready;
      if (req_fired) begin
         filter_pair(gmabr_pkg::sample_pair_type'(req_tdata));
         words_sent++;
      end
      @(negedge clock);
      if (!req_tvalid || req_fired) begin
         if (gap_left > 0) begin
            req_tvalid = 1'b0;
            gap_left--;
         end else if (sample_queue.size() > 0) begin
            next_pair = sample_queue.pop_front();
            req_tdata = next_pair;
            req_tvalid = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
               burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
            end
         end else begin
            req_tvalid = 1'b0;
         end
      end
   end

   // response monitor; ready follows a stall mode that is redrawn at random
   rad_word_type want;
   logic signed [OUT_W-1:0] got_pos, got_vel;
   int unsigned stall_tick = 0;
   int unsigned stall_mode = 0;

   always begin
      @(posedge clock);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pos = rsp_tdata[31:0];
         got_vel = rsp_tdata[63:32];
         if (expected_rad.size() == 0) begin
            $display("%0t: result word with nothing expected: pos %0d vel %0d calib %0b",
                     $time, got_pos, got_vel, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_rad.pop_front();
            if (got_pos !== want.pos) begin
               $display("%0t: pos_rad expected %0d actual %0d", $time, want.pos, got_pos);
               mismatches++;
            end
            if (got_vel !== want.vel) begin
               $display("%0t: vel_rad expected %0d actual %0d", $time, want.vel, got_vel);
               mismatches++;
            end
            if (rsp_tuser !== want.calib) begin
               $display("%0t: calibrating expected %0b actual %0b",
                        $time, want.calib, rsp_tuser);
               mismatches++;
            end
         end
      end
      @(negedge clock);
      stall_tick++;
      if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = ($urandom_range(0, 1) != 0);
         2: rsp_tready = ($urandom_range(0, 3) == 0);
         default: rsp_tready = stall_tick[1] ^ stall_tick[3];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles, %0d results pending",
                     $time, idle_cycles, expected_rad.size());
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
         1: return 16'(200 + $urandom_range(0, 16) - 8);
         2: return 16'(-1500 + $urandom_range(0, 64) - 32);
         3: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_pair(input logic [15:0] p, input logic [15:0] v);
      gmabr_pkg::sample_pair_type s;
      s.pos = p;
      s.vel = v;
      sample_queue = {sample_queue, s};
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++) queue_pair(rand_sample(), rand_sample());
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_tvalid || expected_rad.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_calib_limit(input logic [CNT_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock);
      while (!csr_ready);
      calib_limit = value;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         pos_ring[i] = '0;
         vel_ring[i] = '0;
      end
      ring_slot = '0;
      pos_sum = 0;
      vel_sum = 0;
      pos_bias = 0;
      vel_bias = 0;
      calib_seen = 0;
      calib_limit = gmabr_pkg::CALIB_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero count straight after reset: never calibrating, bias stays zero
      write_calib_limit(16'd0);
      queue_pair(16'h0000, 16'h0000);
      repeat (8) queue_pair(16'h7fff, 16'h8000);
      repeat (8) queue_pair(16'h8000, 16'h7fff);
      queue_pair(16'hffff, 16'h0001);
      queue_pair(16'h0001, 16'hffff);
      queue_pair(16'h5555, 16'haaaa);
      queue_pair(16'haaaa, 16'h5555);
      queue_pair(16'h7fff, 16'h7fff);
      queue_pair(16'h8000, 16'h8000);

      // largest count: calibration resumes from the current counter
      write_calib_limit(16'hffff);
      queue_random(150);
      // sender holds off until every result is back
      wait_drained();
      queue_random(150);

      // bias captured on a window of extremes, then the opposite extremes
      write_calib_limit(CNT_W'(calib_seen + 16));
      repeat (16) queue_pair(16'h8000, 16'h7fff);
      repeat (16) queue_pair(16'h7fff, 16'h8000);
      queue_random(200);

      // count at or below the counter leaves calibration and bias alone
      write_calib_limit(CNT_W'($urandom_range(0, calib_seen)));
      queue_random(200);

      for (int round = 0; round < 6; round++) begin
         if (round == 0) write_calib_limit(CNT_W'(calib_seen));
         else write_calib_limit(CNT_W'(calib_seen + $urandom_range(1, 40)));
         queue_random(150);
      end

      write_calib_limit(gmabr_pkg::CALIB_RESET);
      queue_random(100);

      wait_drained();
      $display("run covered %0d sample words (%0d flagged calibrating) over %0d count writes",
               words_sent, flagged, csr_writes);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
